// File: rtl/ising_spin_flip_energy_assert.svh
// Assertion macros for the spin flip energy block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ISING_SPIN_FLIP_ENERGY_ASSERT_SVH
`define ISING_SPIN_FLIP_ENERGY_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define ISFE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("isfe same-cycle check failed");

// Next-cycle implication, checked outside reset
`define ISFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("isfe next-cycle check failed");

`endif

// File: rtl/isfe_pkg.sv
// Shared types, constants and helpers for the spin flip energy block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package isfe_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_LOAD_NBR = 2'd0,
    KIND_SET_SPIN = 2'd1,
    KIND_FLIP     = 2'd2,
    KIND_TOTALS   = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_SITE_COUNT  = 2'd0;
  localparam logic [1:0] CFG_NBR_COUNT   = 2'd1;
  localparam logic [1:0] CFG_SPIN_LEVELS = 2'd2;

  // Reset values of the registers
  localparam logic [12:0] SITE_COUNT_RST  = 13'd16;
  localparam logic [3:0]  NBR_COUNT_RST   = 4'd4;
  localparam logic [3:0]  SPIN_LEVELS_RST = 4'd2;

  // Datapath widths: spin value, neighbour sum, products, accumulators
  localparam int VAL_W  = 6;
  localparam int SUM_W  = 10;
  localparam int PROD_W = 16;
  localparam int EACC_W = 32;
  localparam int MACC_W = 24;

  // Status from the back end
  typedef struct packed {
    logic idle;
    logic out_busy;
  } status_t;

  // Spin value of a level index; lv is the clamped level count (2..MAX_LEVELS, 8 by default)
  function automatic logic signed [VAL_W-1:0] lvl_value(input logic [2:0] idx,
                                                        input logic [4:0] lv);
    logic [4:0] top;
    logic [4:0] ie;
    top = lv - 5'd1;
    ie  = ({2'b00, idx} > top) ? top : {2'b00, idx};
    return $signed({1'b0, top}) - $signed({ie, 1'b0});
  endfunction

endpackage

// File: rtl/isfe_if.sv
// Channel interfaces of the spin flip energy block: request, result, config.
// No dependencies.
`timescale 1ns / 1ps

interface isfe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [11:0] site;
  logic [3:0]  slot;
  logic [11:0] neighbour_site;
  logic [2:0]  spin_index;
  modport source (output valid, kind, site, slot, neighbour_site, spin_index,
                  input ready);
  modport sink (input valid, kind, site, slot, neighbour_site, spin_index,
                output ready);
endinterface

interface isfe_out_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] delta_energy;
  logic signed [4:0]  delta_magnetization;
  logic signed [10:0] local_energy;
  logic signed [21:0] total_energy;
  logic signed [15:0] total_magnetization;
  modport source (output valid, delta_energy, delta_magnetization, local_energy,
                  total_energy, total_magnetization, input ready);
  modport sink (input valid, delta_energy, delta_magnetization, local_energy,
                total_energy, total_magnetization, output ready);
endinterface

interface isfe_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/isfe_front.sv
// Front end: accepts requests, reduces site indexes modulo the store depth
// and drops out-of-table neighbour loads. Depends on isfe_pkg, isfe_if.
`timescale 1ns / 1ps

module isfe_front #(
  parameter int MAX_SITES = 4096,
  parameter int MAX_NEIGHBOURS = 12,
  localparam int SW = $clog2(MAX_SITES),
  localparam int QW = 2 + SW + 4 + SW + 3
) (
  input  logic          clk,
  input  logic          rst_n,
  isfe_in_if.sink       in_ch,
  output logic          q_push,
  output logic [QW-1:0] q_din,
  input  logic          q_full
);
  import isfe_pkg::*;

  localparam int RSH = 24;
  localparam longint RECIP = ((64'd1 << RSH) + MAX_SITES - 1) / MAX_SITES;

  logic        a_v_r, a_v_nxt;
  logic [1:0]  a_kind_r;
  logic [11:0] a_site_r, a_nsite_r, a_qs_r, a_qn_r;
  logic [3:0]  a_slot_r;
  logic [2:0]  a_idx_r;
  logic        b_v_r, b_v_nxt;
  logic [1:0]  b_kind_r;
  logic [SW-1:0] b_site_r, b_nsite_r;
  logic [3:0]  b_slot_r;
  logic [2:0]  b_idx_r;
  logic        advance;
  logic        keep;
  logic [35:0] ps, pn;
  logic [31:0] rs, rn;

  // Quotient estimate by reciprocal multiply
  assign ps = 36'(in_ch.site) * 36'(RECIP);
  assign pn = 36'(in_ch.neighbour_site) * 36'(RECIP);
  // Remainder from the registered quotient
  assign rs = 32'(a_site_r) - 32'(a_qs_r) * 32'(MAX_SITES);
  assign rn = 32'(a_nsite_r) - 32'(a_qn_r) * 32'(MAX_SITES);

  // Drop loads whose slot lies beyond the table row
  assign keep = (b_kind_r != KIND_LOAD_NBR) || (5'(b_slot_r) < 5'(MAX_NEIGHBOURS));
  assign advance = !b_v_r || !q_full;
  assign in_ch.ready = advance;
  assign q_push = b_v_r && keep && !q_full;
  assign q_din = {b_kind_r, b_site_r, b_slot_r, b_nsite_r, b_idx_r};

  always_comb begin
    a_v_nxt = a_v_r;
    b_v_nxt = b_v_r;
    if (advance) begin
      b_v_nxt = a_v_r;
      a_v_nxt = in_ch.valid;
    end
  end

  // Advance both stages together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
    end
    if (advance) begin
      a_kind_r  <= in_ch.kind;
      a_site_r  <= in_ch.site;
      a_slot_r  <= in_ch.slot;
      a_nsite_r <= in_ch.neighbour_site;
      a_idx_r   <= in_ch.spin_index;
      a_qs_r    <= ps[35:24];
      a_qn_r    <= pn[35:24];
      b_kind_r  <= a_kind_r;
      b_site_r  <= rs[SW-1:0];
      b_slot_r  <= a_slot_r;
      b_nsite_r <= rn[SW-1:0];
      b_idx_r   <= a_idx_r;
    end
  end

endmodule

// File: rtl/isfe_fifo.sv
// Short request queue between the front and back ends.
// Depends on isfe_pkg only by house convention.
`timescale 1ns / 1ps

module isfe_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  import isfe_pkg::*;

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (pop)  rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= din;
  end

endmodule

// File: rtl/isfe_back.sv
// Back end: spin and neighbour memories, the neighbour walk sequencer and
// the result register. Depends on isfe_pkg and isfe_if.
`timescale 1ns / 1ps

module isfe_back #(
  parameter int MAX_SITES = 4096,
  parameter int MAX_NEIGHBOURS = 12,
  localparam int SW = $clog2(MAX_SITES),
  localparam int CW = $clog2(MAX_SITES + 1),
  localparam int NNW = $clog2(MAX_NEIGHBOURS + 1),
  localparam int AW = $clog2(MAX_SITES * MAX_NEIGHBOURS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  isfe_pkg::kind_t  q_kind,
  input  logic [SW-1:0]    q_site,
  input  logic [3:0]       q_slot,
  input  logic [SW-1:0]    q_nsite,
  input  logic [2:0]       q_idx,
  output logic             q_pop,
  input  logic [CW-1:0]    n_sites,
  input  logic [NNW-1:0]   nn,
  input  logic [4:0]       lv,
  isfe_out_if.source       out_ch,
  output isfe_pkg::status_t status
);
  import isfe_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_START = 6'b000010,
    ST_WALK  = 6'b000100,
    ST_PROD  = 6'b001000,
    ST_ACC   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  logic [2:0]    spin_mem [MAX_SITES];
  logic [SW-1:0] nbr_mem [MAX_SITES * MAX_NEIGHBOURS];

  state_t state_r, state_nxt;
  logic [SW-1:0]  c_r, c_nxt;
  logic [2:0]     newidx_r, newidx_nxt;
  logic           is_tot_r, is_tot_nxt;
  logic [AW-1:0]  base_r, base_nxt;
  logic [NNW-1:0] ia_r, ia_nxt, rc_r, rc_nxt;
  logic           nb_pend_r, nb_pend_nxt, sp_nb_r, sp_nb_nxt, sp_ctr_r, sp_ctr_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [VAL_W-1:0]  old_r, old_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt, dprod_r, dprod_nxt;
  logic signed [EACC_W-1:0] e_r, e_nxt, e_half;
  logic signed [MACC_W-1:0] m_r, m_nxt;
  logic           out_v_r, out_v_nxt;
  logic signed [11:0] o_de_r, o_de_nxt;
  logic signed [4:0]  o_dm_r, o_dm_nxt;
  logic signed [10:0] o_le_r, o_le_nxt;
  logic signed [21:0] o_te_r, o_te_nxt;
  logic signed [15:0] o_tm_r, o_tm_nxt;

  logic          spin_we, spin_re, nbr_we, nbr_re;
  logic [SW-1:0] spin_waddr, spin_raddr;
  logic [2:0]    spin_wdata, spin_q;
  logic [AW-1:0] nbr_waddr, nbr_raddr;
  logic [SW-1:0] nbr_wdata, nbr_q;
  logic signed [VAL_W-1:0]   rd_val, newv;
  logic signed [VAL_W:0]     delta;
  logic [NNW-1:0]            rc_inc;

  assign rd_val = lvl_value(spin_q, lv);
  assign newv   = lvl_value(newidx_r, lv);
  assign delta  = (VAL_W + 1)'(newv) - (VAL_W + 1)'(old_r);
  assign e_half = (e_r + EACC_W'(e_r[EACC_W-1])) >>> 1;

  assign status.idle     = (state_r == ST_IDLE);
  assign status.out_busy = out_v_r;

  always_comb begin
    state_nxt   = state_r;
    c_nxt       = c_r;
    newidx_nxt  = newidx_r;
    is_tot_nxt  = is_tot_r;
    base_nxt    = base_r;
    ia_nxt      = ia_r;
    rc_nxt      = rc_r;
    nb_pend_nxt = 1'b0;
    sp_nb_nxt   = 1'b0;
    sp_ctr_nxt  = 1'b0;
    sum_nxt     = sum_r;
    old_nxt     = old_r;
    prod_nxt    = prod_r;
    dprod_nxt   = dprod_r;
    e_nxt       = e_r;
    m_nxt       = m_r;
    out_v_nxt   = out_v_r && !out_ch.ready;
    o_de_nxt    = o_de_r;
    o_dm_nxt    = o_dm_r;
    o_le_nxt    = o_le_r;
    o_te_nxt    = o_te_r;
    o_tm_nxt    = o_tm_r;
    q_pop       = 1'b0;
    spin_we     = 1'b0;
    spin_waddr  = q_site;
    spin_wdata  = q_idx;
    nbr_we      = 1'b0;
    nbr_waddr   = AW'(q_site) * AW'(MAX_NEIGHBOURS) + AW'(q_slot);
    nbr_wdata   = q_nsite;
    spin_re     = 1'b0;
    spin_raddr  = c_r;
    nbr_re      = 1'b0;
    nbr_raddr   = base_r + AW'(ia_r);
    rc_inc      = rc_r + NNW'(sp_nb_r);

    case (state_r)
      // Take the next request; queries wait for a free result register
      ST_IDLE: begin
        if (q_valid) begin
          case (q_kind)
            KIND_LOAD_NBR: begin
              q_pop  = 1'b1;
              nbr_we = 1'b1;
            end
            KIND_SET_SPIN: begin
              q_pop   = 1'b1;
              spin_we = 1'b1;
            end
            KIND_FLIP: begin
              if (!out_v_r) begin
                q_pop      = 1'b1;
                c_nxt      = q_site;
                newidx_nxt = q_idx;
                is_tot_nxt = 1'b0;
                state_nxt  = ST_START;
              end
            end
            default: begin
              if (!out_v_r) begin
                q_pop      = 1'b1;
                c_nxt      = '0;
                is_tot_nxt = 1'b1;
                e_nxt      = '0;
                m_nxt      = '0;
                state_nxt  = ST_START;
              end
            end
          endcase
        end
      end
      // Read the site's own spin and its first neighbour entry
      ST_START: begin
        base_nxt   = AW'(c_r) * AW'(MAX_NEIGHBOURS);
        spin_re    = 1'b1;
        spin_raddr = c_r;
        sp_ctr_nxt = 1'b1;
        nbr_re     = 1'b1;
        nbr_raddr  = base_nxt;
        nb_pend_nxt = 1'b1;
        ia_nxt     = NNW'(1);
        rc_nxt     = '0;
        sum_nxt    = '0;
        state_nxt  = ST_WALK;
      end
      // Stream neighbour entries, then their spins, and accumulate
      ST_WALK: begin
        if (ia_r < nn) begin
          nbr_re      = 1'b1;
          nb_pend_nxt = 1'b1;
          ia_nxt      = ia_r + 1'b1;
        end
        if (nb_pend_r) begin
          spin_re    = 1'b1;
          spin_raddr = nbr_q;
          sp_nb_nxt  = 1'b1;
        end
        if (sp_ctr_r) old_nxt = rd_val;
        if (sp_nb_r)  sum_nxt = sum_r + SUM_W'(rd_val);
        rc_nxt = rc_inc;
        if (rc_inc == nn) state_nxt = ST_PROD;
      end
      // Form bond products
      ST_PROD: begin
        prod_nxt  = PROD_W'(old_r) * PROD_W'(sum_r);
        dprod_nxt = PROD_W'(delta) * PROD_W'(sum_r);
        state_nxt = ST_ACC;
      end
      // Deliver a flip result or fold the site into the totals
      ST_ACC: begin
        if (!is_tot_r) begin
          o_de_nxt  = 12'(PROD_W'(0) - dprod_r);
          o_dm_nxt  = 5'(delta);
          o_le_nxt  = 11'(PROD_W'(0) - prod_r);
          o_te_nxt  = '0;
          o_tm_nxt  = '0;
          out_v_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          e_nxt = e_r - EACC_W'(prod_r);
          m_nxt = m_r + MACC_W'(old_r);
          if (CW'(c_r) + CW'(1) == n_sites) begin
            state_nxt = ST_EMIT;
          end else begin
            c_nxt     = c_r + 1'b1;
            state_nxt = ST_START;
          end
        end
      end
      // Deliver the totals
      ST_EMIT: begin
        o_de_nxt  = '0;
        o_dm_nxt  = '0;
        o_le_nxt  = '0;
        o_te_nxt  = 22'(e_half);
        o_tm_nxt  = 16'(m_r);
        out_v_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Memories with registered read data
  always_ff @(posedge clk) begin
    if (spin_we) spin_mem[spin_waddr] <= spin_wdata;
    if (spin_re) spin_q <= spin_mem[spin_raddr];
    if (nbr_we) nbr_mem[nbr_waddr] <= nbr_wdata;
    if (nbr_re) nbr_q <= nbr_mem[nbr_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_v_r   <= 1'b0;
      nb_pend_r <= 1'b0;
      sp_nb_r   <= 1'b0;
      sp_ctr_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_v_r   <= out_v_nxt;
      nb_pend_r <= nb_pend_nxt;
      sp_nb_r   <= sp_nb_nxt;
      sp_ctr_r  <= sp_ctr_nxt;
    end
    c_r      <= c_nxt;
    newidx_r <= newidx_nxt;
    is_tot_r <= is_tot_nxt;
    base_r   <= base_nxt;
    ia_r     <= ia_nxt;
    rc_r     <= rc_nxt;
    sum_r    <= sum_nxt;
    old_r    <= old_nxt;
    prod_r   <= prod_nxt;
    dprod_r  <= dprod_nxt;
    e_r      <= e_nxt;
    m_r      <= m_nxt;
    o_de_r   <= o_de_nxt;
    o_dm_r   <= o_dm_nxt;
    o_le_r   <= o_le_nxt;
    o_te_r   <= o_te_nxt;
    o_tm_r   <= o_tm_nxt;
  end

  assign out_ch.valid               = out_v_r;
  assign out_ch.delta_energy        = o_de_r;
  assign out_ch.delta_magnetization = o_dm_r;
  assign out_ch.local_energy        = o_le_r;
  assign out_ch.total_energy        = o_te_r;
  assign out_ch.total_magnetization = o_tm_r;

endmodule

// File: rtl/ising_spin_flip_energy.sv
// Spin flip energy block: top level with configuration registers.
// Depends on isfe_pkg, isfe_if, isfe_front, isfe_fifo, isfe_back.
//
// Usage: requests enter on in_ch (valid/ready). Kind 0 loads one neighbour
// table entry, kind 1 sets a site's spin level; neither gives a result.
// Kind 2 returns delta_energy, delta_magnetization and local_energy; kind 3
// returns total_energy and total_magnetization on out_ch (valid/ready).
// Configuration writes on cfg_ch are always accepted; write only while idle.
// Structure: two front stages, then a four-entry queue. A flip query's
// walk is paced by the single read port of the spin memory, which serves
// the site and then one neighbour spin per cycle. A totals query walks
// each site in turn.
// Reset clears the control state and sets the registers to 16, 4 and 2;
// the memories are not cleared and must be written before use.
// A stalled receiver holds the result register; loads and sets ahead of the
// next query keep flowing, and that query and all behind it wait in the queue until the result is taken.
`timescale 1ns / 1ps
`include "ising_spin_flip_energy_assert.svh"

module ising_spin_flip_energy #(
  parameter int MAX_SITES = 4096,
  parameter int MAX_NEIGHBOURS = 12,
  parameter int MAX_LEVELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  isfe_in_if.sink     in_ch,
  isfe_out_if.source  out_ch,
  isfe_cfg_if.sink    cfg_ch
);
  import isfe_pkg::*;

  localparam int SW  = $clog2(MAX_SITES);
  localparam int CW  = $clog2(MAX_SITES + 1);
  localparam int NNW = $clog2(MAX_NEIGHBOURS + 1);
  localparam int QW  = 2 + SW + 4 + SW + 3;

  logic [12:0] site_count_r;
  logic [3:0]  nbr_count_r, spin_levels_r;
  logic [CW-1:0]  n_sites;
  logic [NNW-1:0] nn;
  logic [4:0]     lv;
  logic           q_push, q_full, q_pop, q_empty;
  logic [QW-1:0]  q_din, q_dout;
  status_t        status;

  // Hold configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      site_count_r  <= SITE_COUNT_RST;
      nbr_count_r   <= NBR_COUNT_RST;
      spin_levels_r <= SPIN_LEVELS_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_SITE_COUNT:  site_count_r  <= cfg_ch.data;
        CFG_NBR_COUNT:   nbr_count_r   <= cfg_ch.data[3:0];
        CFG_SPIN_LEVELS: spin_levels_r <= cfg_ch.data[3:0];
        default: ;
      endcase
    end
  end

  // Clamp registers to their usable ranges
  always_comb begin
    if (site_count_r == '0) n_sites = CW'(1);
    else if (32'(site_count_r) > MAX_SITES) n_sites = CW'(MAX_SITES);
    else n_sites = CW'(site_count_r);
    if (nbr_count_r == '0) nn = NNW'(1);
    else if (32'(nbr_count_r) > MAX_NEIGHBOURS) nn = NNW'(MAX_NEIGHBOURS);
    else nn = NNW'(nbr_count_r);
    if (spin_levels_r < 4'd2) lv = 5'd2;
    else if (32'(spin_levels_r) > MAX_LEVELS) lv = 5'(MAX_LEVELS);
    else lv = 5'(spin_levels_r);
  end

  isfe_front #(.MAX_SITES(MAX_SITES), .MAX_NEIGHBOURS(MAX_NEIGHBOURS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_push (q_push),
    .q_din  (q_din),
    .q_full (q_full)
  );

  isfe_fifo #(.W(QW), .DEPTH(4)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  isfe_back #(.MAX_SITES(MAX_SITES), .MAX_NEIGHBOURS(MAX_NEIGHBOURS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (!q_empty),
    .q_kind  (kind_t'(q_dout[QW-1 -: 2])),
    .q_site  (q_dout[QW-3 -: SW]),
    .q_slot  (q_dout[SW+6 : SW+3]),
    .q_nsite (q_dout[SW+2 : 3]),
    .q_idx   (q_dout[2:0]),
    .q_pop   (q_pop),
    .n_sites (n_sites),
    .nn      (nn),
    .lv      (lv),
    .out_ch  (out_ch),
    .status  (status)
  );

  `ISFE_ASSERT_NOW(a_no_push_full, q_full, !q_push)
  `ISFE_ASSERT_NOW(a_no_pop_empty, q_empty, !q_pop)
  `ISFE_ASSERT_NOW(a_pop_only_idle, q_pop, status.idle)
  `ISFE_ASSERT_NEXT(a_result_leaves_idle, !status.idle && !status.out_busy && out_ch.valid, 1'b0)

endmodule
